### sv/brpb_pkg.sv
// ----------------------------------------------------------------------------
// brpb_pkg
// Shared types and constants of the PackBits run-length encoder: the byte
// source select, and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package brpb_pkg;

  // output stream layout
  localparam int unsigned PACKED_W   = 64;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned OUT_DATA_W = 72;

  // source of the byte pushed into the word assembler
  typedef enum logic [2:0] {
    SEL_L1_HDR = 3'd0,  // header of a literal made of stored bytes only
    SEL_L2_HDR = 3'd1,  // header of a literal that ends with the newest byte
    SEL_R_HDR  = 3'd2,  // repeat header, minus (length - 1)
    SEL_R_VAL  = 3'd3,  // repeat value
    SEL_MEM    = 3'd4,  // literal byte from the store
    SEL_LA     = 3'd5   // newest byte closing a flushed literal
  } byte_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;     // input beat taken this cycle
    logic      fin;        // that beat ends the stream
    logic      commit;     // write lookahead into the literal store
    logic      lc_clr;     // literal count goes back to zero
    logic      rep_start;  // new repeat run of two bytes
    logic      rep_inc;    // repeat run grows by one
    logic      push;       // push one byte into the word assembler
    byte_sel_t sel;
    logic      seg_last;   // pushed byte ends its segment
    logic      step_last;  // pushed byte ends the last segment of the step
    logic      stream_last;
    logic      k_inc;      // advance the store read index
    logic      k_clr;      // rewind the store read index
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eq_la;      // input byte equals lookahead
    logic eq_rv;      // input byte equals repeat value
    logic lit_full;   // one more committed byte fills the literal
    logic rep_full;   // one more equal byte fills the repeat
    logic k_last_l1;  // read index at last byte of the first literal
    logic k_last_l2;  // read index at last stored byte of the flushed literal
    logic l2_empty;   // flushed literal has no stored bytes
    logic push_ok;    // push can be taken this cycle
  } status_t;

endpackage

### sv/brpb_ctrl.sv
// ----------------------------------------------------------------------------
// brpb_ctrl
// Controller of the PackBits encoder: keeps the run mode, decides at each
// input beat which segments are closed, and walks the segment bytes out.
// ----------------------------------------------------------------------------
module brpb_ctrl #(
  parameter int unsigned MAX_REPEAT_STEPS = 127
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic               s_axis_tlast,
  input  brpb_pkg::status_t  status,
  output brpb_pkg::cmd_t     cmd
);

  // run modes
  localparam logic [1:0] MODE_EMPTY   = 2'd0;
  localparam logic [1:0] MODE_ONE     = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;
  localparam logic [1:0] MODE_LITERAL = 2'd3;

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_L1_HDR  = 3'd1;
  localparam logic [2:0] ST_L1_BODY = 3'd2;
  localparam logic [2:0] ST_R_HDR   = 3'd3;
  localparam logic [2:0] ST_R_VAL   = 3'd4;
  localparam logic [2:0] ST_L2_HDR  = 3'd5;
  localparam logic [2:0] ST_L2_BODY = 3'd6;
  localparam logic [2:0] ST_L2_LA   = 3'd7;

  // a fresh two-byte repeat is already full
  localparam logic START_FULL = (MAX_REPEAT_STEPS <= 1);

  logic [2:0] state, state_next;
  logic [1:0] mode, mode_next, mode_a;
  logic       do_r, do_l2, fin_q;
  logic       accept;
  logic       pl1, pr, pl2;
  logic       adv;

  // run bookkeeping commands
  logic       commit, lc_clr, rep_start, rep_inc;

  // sequencer commands
  logic                 push, seg_last, step_last, stream_last, k_inc, k_clr;
  brpb_pkg::byte_sel_t  sel;

  assign accept        = s_axis_tvalid && (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE);

  // segment plan for the incoming byte
  always_comb begin
    mode_a    = mode;
    pl1       = 1'b0;
    pr        = 1'b0;
    pl2       = 1'b0;
    commit    = 1'b0;
    lc_clr    = 1'b0;
    rep_start = 1'b0;
    rep_inc   = 1'b0;
    unique case (mode)
      MODE_EMPTY: begin
        mode_a = MODE_ONE;
      end
      MODE_ONE: begin
        if (status.eq_la) begin
          rep_start = 1'b1;
          pr        = START_FULL;
          mode_a    = START_FULL ? MODE_EMPTY : MODE_REPEAT;
        end else begin
          commit = 1'b1;
          if (status.lit_full) begin
            pl1    = 1'b1;
            lc_clr = 1'b1;
            mode_a = MODE_ONE;
          end else begin
            mode_a = MODE_LITERAL;
          end
        end
      end
      MODE_REPEAT: begin
        if (status.eq_rv) begin
          rep_inc = 1'b1;
          pr      = status.rep_full;
          mode_a  = status.rep_full ? MODE_EMPTY : MODE_REPEAT;
        end else begin
          pr     = 1'b1;
          mode_a = MODE_ONE;
        end
      end
      MODE_LITERAL: begin
        if (status.eq_la) begin
          pl1       = 1'b1;
          lc_clr    = 1'b1;
          rep_start = 1'b1;
          pr        = START_FULL;
          mode_a    = START_FULL ? MODE_EMPTY : MODE_REPEAT;
        end else begin
          commit = 1'b1;
          if (status.lit_full) begin
            pl1    = 1'b1;
            lc_clr = 1'b1;
            mode_a = MODE_ONE;
          end else begin
            mode_a = MODE_LITERAL;
          end
        end
      end
    endcase
    // end of stream flushes what is pending
    mode_next = mode_a;
    if (s_axis_tlast) begin
      if ((mode_a == MODE_ONE) || (mode_a == MODE_LITERAL)) begin
        pl2 = 1'b1;
      end else if (mode_a == MODE_REPEAT) begin
        pr = 1'b1;
      end
      mode_next = MODE_EMPTY;
    end
  end

  // byte sequencer
  always_comb begin
    state_next = state;
    push       = 1'b1;
    sel        = brpb_pkg::SEL_MEM;
    seg_last   = 1'b0;
    step_last  = 1'b0;
    k_inc      = 1'b0;
    k_clr      = 1'b0;
    adv        = status.push_ok;
    unique case (state)
      ST_IDLE: begin
        push = 1'b0;
        adv  = 1'b0;
        if (accept) begin
          priority if (pl1) begin
            state_next = ST_L1_HDR;
          end else if (pr) begin
            state_next = ST_R_HDR;
          end else if (pl2) begin
            state_next = ST_L2_HDR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_L1_HDR: begin
        sel = brpb_pkg::SEL_L1_HDR;
        if (adv) state_next = ST_L1_BODY;
      end
      ST_L1_BODY: begin
        sel       = brpb_pkg::SEL_MEM;
        seg_last  = status.k_last_l1;
        step_last = status.k_last_l1 && !do_r && !do_l2;
        if (adv) begin
          if (status.k_last_l1) begin
            k_clr      = 1'b1;
            state_next = do_r ? ST_R_HDR : (do_l2 ? ST_L2_HDR : ST_IDLE);
          end else begin
            k_inc = 1'b1;
          end
        end
      end
      ST_R_HDR: begin
        sel = brpb_pkg::SEL_R_HDR;
        if (adv) state_next = ST_R_VAL;
      end
      ST_R_VAL: begin
        sel       = brpb_pkg::SEL_R_VAL;
        seg_last  = 1'b1;
        step_last = !do_l2;
        if (adv) state_next = do_l2 ? ST_L2_HDR : ST_IDLE;
      end
      ST_L2_HDR: begin
        sel = brpb_pkg::SEL_L2_HDR;
        if (adv) state_next = status.l2_empty ? ST_L2_LA : ST_L2_BODY;
      end
      ST_L2_BODY: begin
        sel = brpb_pkg::SEL_MEM;
        if (adv) begin
          if (status.k_last_l2) begin
            k_clr      = 1'b1;
            state_next = ST_L2_LA;
          end else begin
            k_inc = 1'b1;
          end
        end
      end
      ST_L2_LA: begin
        sel       = brpb_pkg::SEL_LA;
        seg_last  = 1'b1;
        step_last = 1'b1;
        if (adv) state_next = ST_IDLE;
      end
    endcase
    stream_last = step_last && fin_q;
  end

  // command group to the datapath
  always_comb begin
    cmd.accept      = accept;
    cmd.fin         = s_axis_tlast;
    cmd.commit      = commit;
    cmd.lc_clr      = lc_clr;
    cmd.rep_start   = rep_start;
    cmd.rep_inc     = rep_inc;
    cmd.push        = push;
    cmd.sel         = sel;
    cmd.seg_last    = seg_last;
    cmd.step_last   = step_last;
    cmd.stream_last = stream_last;
    cmd.k_inc       = k_inc;
    cmd.k_clr       = k_clr;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode  <= MODE_EMPTY;
      do_r  <= 1'b0;
      do_l2 <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        mode  <= mode_next;
        do_r  <= pr;
        do_l2 <= pl2;
        fin_q <= s_axis_tlast;
      end
    end
  end

endmodule

### sv/brpb_datapath.sv
// ----------------------------------------------------------------------------
// brpb_datapath
// Datapath of the PackBits encoder: lookahead and run registers, the literal
// store, the word assembler and the output register.
// ----------------------------------------------------------------------------
module brpb_datapath #(
  parameter int unsigned MAX_LITERAL      = 128,
  parameter int unsigned MAX_REPEAT_STEPS = 127,
  parameter int unsigned WORD_BYTES       = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [7:0]                     data_byte,
  input  brpb_pkg::cmd_t                 cmd,
  output brpb_pkg::status_t              status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [brpb_pkg::PACKED_W-1:0]  out_packed,
  output logic [brpb_pkg::COUNT_W-1:0]   out_count,
  output logic                           out_seg_end,
  output logic                           out_item_done,
  output logic                           out_stream_done
);

  localparam int unsigned LW  = $clog2(MAX_LITERAL);
  localparam int unsigned CW  = $clog2(MAX_LITERAL + 1);
  localparam int unsigned RLW = $clog2(MAX_REPEAT_STEPS + 2);
  localparam int unsigned AW  = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int unsigned WW  = WORD_BYTES * 8;

  logic [7:0]     la, rv, rep_val, rdata, push_byte;
  logic [RLW-1:0] rl, rl_pre, rep_len;
  logic [CW-1:0]  lc, lc_plus, lc_a, l1_cnt, l2_cnt, k, k_next;
  logic [AW-1:0]  asm_cnt;
  logic [WW-1:0]  asm_data, word;
  logic           word_done, fire;
  logic [7:0]     store [MAX_LITERAL];

  // run bookkeeping for the incoming byte
  assign lc_plus = lc + CW'(cmd.commit);
  assign lc_a    = cmd.lc_clr ? '0 : lc_plus;
  assign rl_pre  = cmd.rep_start ? RLW'(2) : (cmd.rep_inc ? rl + RLW'(1) : rl);

  always_ff @(posedge clk) begin
    if (rst) begin
      lc <= '0;
      rl <= '0;
    end else if (cmd.accept) begin
      lc <= cmd.fin ? '0 : lc_a;
      rl <= cmd.fin ? '0 : rl_pre;
    end
  end

  // lookahead, run value and captured segment parameters
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      la      <= data_byte;
      rep_val <= cmd.rep_start ? data_byte : rv;
      rep_len <= rl_pre;
      l1_cnt  <= lc_plus;
      l2_cnt  <= lc_a;
      if (cmd.rep_start) rv <= data_byte;
    end
  end

  // literal store, read data always reflects the next read index
  assign k_next = cmd.k_clr ? '0 : (cmd.k_inc ? k + CW'(1) : k);

  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.commit) store[lc[LW-1:0]] <= la;
    rdata <= store[k_next[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) k <= '0;
    else     k <= k_next;
  end

  // status
  assign status.eq_la     = (data_byte == la);
  assign status.eq_rv     = (data_byte == rv);
  assign status.lit_full  = (lc >= CW'(MAX_LITERAL - 1));
  assign status.rep_full  = (rl >= RLW'(MAX_REPEAT_STEPS));
  assign status.k_last_l1 = (k == l1_cnt - CW'(1));
  assign status.k_last_l2 = (k == l2_cnt - CW'(1));
  assign status.l2_empty  = (l2_cnt == '0);
  assign status.push_ok   = !word_done || !out_valid || out_ready;

  // byte source
  always_comb begin
    unique case (cmd.sel)
      brpb_pkg::SEL_L1_HDR: push_byte = 8'(l1_cnt - CW'(1));
      brpb_pkg::SEL_L2_HDR: push_byte = 8'(l2_cnt);
      brpb_pkg::SEL_R_HDR:  push_byte = 8'd0 - 8'(rep_len - RLW'(1));
      brpb_pkg::SEL_R_VAL:  push_byte = rep_val;
      brpb_pkg::SEL_MEM:    push_byte = rdata;
      brpb_pkg::SEL_LA:     push_byte = la;
      default:              push_byte = 8'd0;
    endcase
  end

  // word assembly, lanes past the new byte stay zero
  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (asm_cnt == AW'(i))     word[i*8 +: 8] = push_byte;
      else if (asm_cnt > AW'(i)) word[i*8 +: 8] = asm_data[i*8 +: 8];
      else                       word[i*8 +: 8] = 8'd0;
    end
  end

  assign word_done = cmd.seg_last || (asm_cnt == AW'(WORD_BYTES - 1));
  assign fire      = cmd.push && status.push_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      asm_cnt <= '0;
    end else if (fire) begin
      asm_cnt <= word_done ? '0 : asm_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) asm_data <= word;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && word_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && word_done) begin
      out_packed      <= brpb_pkg::PACKED_W'(word);
      out_count       <= brpb_pkg::COUNT_W'(asm_cnt) + brpb_pkg::COUNT_W'(1);
      out_seg_end     <= cmd.seg_last;
      out_item_done   <= cmd.step_last;
      out_stream_done <= cmd.stream_last;
    end
  end

endmodule

### sv/byterun_packbits_encoder_unit.sv
// ----------------------------------------------------------------------------
// byterun_packbits_encoder_unit
// Streaming PackBits (ByteRun) compressor: one byte per input beat, coded
// repeat and literal segments out as words of up to WORD_BYTES bytes.
// ----------------------------------------------------------------------------
// Input channel s_axis: one uncompressed byte per beat in tdata, tlast on
// the last byte of a stream. Output channel m_axis: one word per beat, the
// first segment byte in the low bits, byte count and flags beside it, tlast
// on the last word of a stream. Every segment starts a new word.
// An input beat is taken while the sequencer is idle; the segments it
// closes are then walked out at one byte per cycle, unless the receiver
// stalls, through the single-byte port of the literal store and the word
// assembler: a repeat as its header and its value, a literal of n bytes as
// its header and its n bytes. No new input byte is taken while segments are
// walked out; a byte that closes no segment leaves the sequencer idle. Each
// finished word is held in the output register.
// Reset empties the encoder and the output register; a new stream may start
// at once. When the receiver stalls, the finished word waits in the output
// register and assembly pauses only when the next word is complete.
// ----------------------------------------------------------------------------
module byterun_packbits_encoder_unit #(
  parameter int unsigned MAX_LITERAL      = 128,
  parameter int unsigned MAX_REPEAT_STEPS = 127,
  parameter int unsigned WORD_BYTES       = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // data_byte
  input  logic                              s_axis_tlast,   // final_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // packed_bytes[63:0], byte_count[67:64], segment_end[68], item_done[69]
  output logic [brpb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast    // stream_done
);

  brpb_pkg::cmd_t                  cmd;
  brpb_pkg::status_t               status;
  logic [brpb_pkg::PACKED_W-1:0]   out_packed;
  logic [brpb_pkg::COUNT_W-1:0]    out_count;
  logic                            out_seg_end;
  logic                            out_item_done;

  // run decisions and byte sequencing
  brpb_ctrl #(
    .MAX_REPEAT_STEPS (MAX_REPEAT_STEPS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .status        (status),
    .cmd           (cmd)
  );

  // storage, assembly and output register
  brpb_datapath #(
    .MAX_LITERAL      (MAX_LITERAL),
    .MAX_REPEAT_STEPS (MAX_REPEAT_STEPS),
    .WORD_BYTES       (WORD_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .data_byte       (s_axis_tdata),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_packed      (out_packed),
    .out_count       (out_count),
    .out_seg_end     (out_seg_end),
    .out_item_done   (out_item_done),
    .out_stream_done (m_axis_tlast)
  );

  // output beat layout
  assign m_axis_tdata = {2'b00, out_item_done, out_seg_end, out_count, out_packed};

endmodule
